// ----- rtl/rlph_pkg.sv -----
// Shared types and constants for the RLP header stream decoder.
package rlph_pkg;

    // Parser phase; the spare code is treated as expecting a header.
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_e_t;

    // Role of one byte of the stream.
    typedef enum logic [1:0] {
        ROLE_HEADER  = 2'd0,
        ROLE_LENGTH  = 2'd1,
        ROLE_PAYLOAD = 2'd2,
        ROLE_SINGLE  = 2'd3
    } role_e_t;

    // Item kinds.
    localparam logic KIND_STRING = 1'b0;
    localparam logic KIND_LIST   = 1'b1;

    // Boundaries of the prefix byte ranges.
    localparam logic [7:0] SINGLE_MAX     = 8'h7F;
    localparam logic [7:0] STR_BASE       = 8'h80;
    localparam logic [7:0] STR_SHORT_MAX  = 8'hB7;
    localparam logic [7:0] STR_LONG_MAX   = 8'hBF;
    localparam logic [7:0] LIST_BASE      = 8'hC0;
    localparam logic [7:0] LIST_SHORT_MAX = 8'hF7;

    localparam int LEN_W = 64;

    // Parser state carried from byte to byte.
    typedef struct packed {
        phase_e_t           phase;
        logic [3:0]         len_left;
        logic [LEN_W-1:0]   accum;
        logic [LEN_W-1:0]   payload_left;
        logic               pend_kind;
    } parse_state_t;

    // Labels produced for one byte.
    typedef struct packed {
        role_e_t            role;
        logic               kind;
        logic [LEN_W-1:0]   length;
        logic               done;
        logic               last;
        logic [7:0]         data;
    } byte_label_t;

endpackage

// ----- rtl/rlph_step.sv -----
// Combinational decode of one stream byte against the current parser state.
module rlph_step
(
    input  rlph_pkg::parse_state_t cur,
    input  logic [7:0]             data_byte,
    output rlph_pkg::parse_state_t nxt,
    output rlph_pkg::byte_label_t  res
);

    logic [rlph_pkg::LEN_W-1:0] accum_new;
    logic [3:0]                 left_new;
    logic [rlph_pkg::LEN_W-1:0] pay_dec;
    logic [7:0]                 diff_str;
    logic [7:0]                 diff_list;
    logic [7:0]                 diff_strl;
    logic [7:0]                 diff_listl;

    // Arithmetic shared by the phase arms.
    always_comb
    begin
        diff_str   = data_byte - rlph_pkg::STR_BASE;
        diff_list  = data_byte - rlph_pkg::LIST_BASE;
        diff_strl  = data_byte - rlph_pkg::STR_SHORT_MAX;
        diff_listl = data_byte - rlph_pkg::LIST_SHORT_MAX;
        if (cur.len_left != 4'd0)
        begin
            accum_new = {cur.accum[rlph_pkg::LEN_W-9:0], data_byte};
            left_new  = cur.len_left - 4'd1;
        end
        else
        begin
            accum_new = cur.accum;
            left_new  = cur.len_left;
        end
        if (cur.payload_left != '0)
            pay_dec = cur.payload_left - rlph_pkg::LEN_W'(1);
        else
            pay_dec = cur.payload_left;
    end

    // Next state and byte labels.
    always_comb
    begin
        nxt        = cur;
        res.role   = rlph_pkg::ROLE_HEADER;
        res.kind   = rlph_pkg::KIND_STRING;
        res.length = '0;
        res.done   = 1'b0;
        res.last   = 1'b0;
        res.data   = data_byte;

        unique case (cur.phase)
            rlph_pkg::PH_PAYLOAD:
            begin
                // String payload: count down and flag the final byte.
                nxt.payload_left = pay_dec;
                res.role         = rlph_pkg::ROLE_PAYLOAD;
                res.last         = (pay_dec == '0);
                if (pay_dec == '0)
                    nxt.phase = rlph_pkg::PH_HEADER;
            end
            rlph_pkg::PH_LENGTH:
            begin
                // Long-form length byte, most significant first.
                nxt.accum    = accum_new;
                nxt.len_left = left_new;
                res.role     = rlph_pkg::ROLE_LENGTH;
                if (left_new == 4'd0)
                begin
                    res.kind   = cur.pend_kind;
                    res.length = accum_new;
                    res.done   = 1'b1;
                    if (cur.pend_kind == rlph_pkg::KIND_STRING && accum_new != '0)
                    begin
                        nxt.payload_left = accum_new;
                        nxt.phase        = rlph_pkg::PH_PAYLOAD;
                    end
                    else
                        nxt.phase = rlph_pkg::PH_HEADER;
                end
            end
            default:
            begin
                // Header byte expected.
                nxt.phase = rlph_pkg::PH_HEADER;
                if (data_byte <= rlph_pkg::SINGLE_MAX)
                begin
                    res.role   = rlph_pkg::ROLE_SINGLE;
                    res.length = rlph_pkg::LEN_W'(1);
                    res.done   = 1'b1;
                    res.last   = 1'b1;
                end
                else if (data_byte <= rlph_pkg::STR_SHORT_MAX)
                begin
                    res.length = {56'd0, diff_str};
                    res.done   = 1'b1;
                    if (diff_str != 8'd0)
                    begin
                        nxt.payload_left = {56'd0, diff_str};
                        nxt.phase        = rlph_pkg::PH_PAYLOAD;
                    end
                end
                else if (data_byte <= rlph_pkg::STR_LONG_MAX)
                begin
                    nxt.len_left  = diff_strl[3:0];
                    nxt.accum     = '0;
                    nxt.pend_kind = rlph_pkg::KIND_STRING;
                    nxt.phase     = rlph_pkg::PH_LENGTH;
                end
                else if (data_byte <= rlph_pkg::LIST_SHORT_MAX)
                begin
                    res.kind   = rlph_pkg::KIND_LIST;
                    res.length = {56'd0, diff_list};
                    res.done   = 1'b1;
                end
                else
                begin
                    nxt.len_left  = diff_listl[3:0];
                    nxt.accum     = '0;
                    nxt.pend_kind = rlph_pkg::KIND_LIST;
                    nxt.phase     = rlph_pkg::PH_LENGTH;
                end
            end
        endcase
    end

endmodule

// ----- rtl/rlp_header_stream_decoder_core.sv -----
// A byte request that is accepted is held in the input register, then decoded into the result register.
// Throughput: one byte per cycle while m_axis_tready is not held low; the input register
// and the result register each take a new byte whenever the stage after them moves on,
// and the parser state is updated in the same cycle as the result register is loaded.
// Reset: rst_n clears the parser state to expecting a header and empties both stages.
// Top level of the RLP header stream decoder.
module rlp_header_stream_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [63:0] item_length, [71:64] data_out
    output logic [7:0]  m_axis_tuser,   // [1:0] byte_role, [2] item_kind,
                                        // [3] header_done, [7:4] zero
    output logic        m_axis_tlast    // payload_last
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   out_valid_reg;
    rlph_pkg::byte_label_t  out_reg;
    rlph_pkg::parse_state_t state_reg;
    rlph_pkg::parse_state_t state_next;
    rlph_pkg::byte_label_t  label_next;
    logic                   out_load;
    logic                   step_go;

    // Handshake control of the two stages.
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign step_go       = in_valid_reg && out_load;
    assign s_axis_tready = !in_valid_reg || out_load;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
    end

    // Decode of the held byte.
    rlph_step u_step
    (
        .cur       (state_reg),
        .data_byte (in_byte_reg),
        .nxt       (state_next),
        .res       (label_next)
    );

    // Parser state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= rlph_pkg::PH_HEADER;
            state_reg.len_left     <= 4'd0;
            state_reg.accum        <= '0;
            state_reg.payload_left <= '0;
            state_reg.pend_kind    <= rlph_pkg::KIND_STRING;
        end
        else if (step_go)
            state_reg <= state_next;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_go)
            out_reg <= label_next;
    end

    // Output packing.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.data, out_reg.length};
    assign m_axis_tuser  = {4'd0, out_reg.done, out_reg.kind, out_reg.role};
    assign m_axis_tlast  = out_reg.last;

    // A string payload phase always has bytes still due.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == rlph_pkg::PH_PAYLOAD |-> state_reg.payload_left != '0)
        else $error("payload phase with no bytes left");

    // A length phase always has length bytes still due.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == rlph_pkg::PH_LENGTH |-> state_reg.len_left != 4'd0)
        else $error("length phase with no bytes left");

    // A byte decoded in the payload phase leaves as a payload byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_go && state_reg.phase == rlph_pkg::PH_PAYLOAD
        |=> out_reg.role == rlph_pkg::ROLE_PAYLOAD && !out_reg.done)
        else $error("payload byte mislabelled");

    // A held byte that cannot move blocks new requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_load |-> !s_axis_tready)
        else $error("input accepted while stage is blocked");

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the RLP header stream decoder: directed table then random streams.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rlph_pkg::*;

    // One row of stimulus; a fixed row carries its expected label typed in.
    typedef struct {
        logic [7:0]  b;
        bit          fixed;
        byte_label_t lbl;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic [7:0]  m_axis_tuser;
    logic        m_axis_tlast;

    stim_row_t   rows[$];
    byte_label_t labels_due[$];
    byte_label_t fixed_lbl;
    bit          fixed_use = 1'b0;
    bit          byte_taken = 1'b0;
    bit          no_idle = 1'b0;
    int          mismatch_count = 0;
    int          n_directed;

    // Parser state of the bench's own decoder, at its reset values.
    phase_e_t    dec_phase = PH_HEADER;
    logic [3:0]  dec_len_left = '0;
    logic [63:0] dec_accum = '0;
    logic [63:0] dec_pay_left = '0;
    logic        dec_kind = KIND_STRING;

    rlp_header_stream_decoder_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Labels one byte and advances the decoder state.
    function automatic byte_label_t label_byte(logic [7:0] b);
        byte_label_t r;
        r = '0;
        r.data = b;
        if (dec_phase == PH_PAYLOAD)
        begin
            if (dec_pay_left != 64'd0)
                dec_pay_left = dec_pay_left - 64'd1;
            r.role = ROLE_PAYLOAD;
            r.last = (dec_pay_left == 64'd0);
            if (r.last)
                dec_phase = PH_HEADER;
        end
        else if (dec_phase == PH_LENGTH)
        begin
            if (dec_len_left != 4'd0)
            begin
                dec_accum = {dec_accum[55:0], b};
                dec_len_left = dec_len_left - 4'd1;
            end
            r.role = ROLE_LENGTH;
            if (dec_len_left == 4'd0)
            begin
                r.done = 1'b1;
                r.kind = dec_kind;
                r.length = dec_accum;
                if (dec_kind == KIND_STRING && dec_accum != 64'd0)
                begin
                    dec_pay_left = dec_accum;
                    dec_phase = PH_PAYLOAD;
                end
                else
                    dec_phase = PH_HEADER;
            end
        end
        else
        begin
            // Any other phase code is taken as expecting a header.
            dec_phase = PH_HEADER;
            r.role = ROLE_HEADER;
            if (b <= SINGLE_MAX)
            begin
                r.role = ROLE_SINGLE;
                r.length = 64'd1;
                r.done = 1'b1;
                r.last = 1'b1;
            end
            else if (b <= STR_SHORT_MAX)
            begin
                r.length = 64'(b - STR_BASE);
                r.done = 1'b1;
                if (r.length != 64'd0)
                begin
                    dec_pay_left = r.length;
                    dec_phase = PH_PAYLOAD;
                end
            end
            else if (b <= STR_LONG_MAX)
            begin
                dec_len_left = 4'(b - STR_SHORT_MAX);
                dec_accum = '0;
                dec_kind = KIND_STRING;
                dec_phase = PH_LENGTH;
            end
            else if (b <= LIST_SHORT_MAX)
            begin
                r.kind = KIND_LIST;
                r.length = 64'(b - LIST_BASE);
                r.done = 1'b1;
            end
            else
            begin
                dec_len_left = 4'(b - LIST_SHORT_MAX);
                dec_accum = '0;
                dec_kind = KIND_LIST;
                dec_phase = PH_LENGTH;
            end
        end
        return r;
    endfunction

    function automatic void add_row(logic [7:0] b);
        stim_row_t row;
        row.b = b;
        row.fixed = 1'b0;
        row.lbl = '0;
        rows.push_back(row);
    endfunction

    function automatic void add_fixed(logic [7:0] b, role_e_t role, logic kind,
                                      logic [63:0] len, logic done, logic last);
        stim_row_t row;
        row.b = b;
        row.fixed = 1'b1;
        row.lbl.role = role;
        row.lbl.kind = kind;
        row.lbl.length = len;
        row.lbl.done = done;
        row.lbl.last = last;
        row.lbl.data = b;
        rows.push_back(row);
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    // Appends one item of a random stream: mostly well formed, some noise and
    // strings cut short.
    function automatic void add_random_item();
        int pick;
        int n;
        int len;
        int cut;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            add_row(8'($urandom_range(0, 127)));
        else if (pick < 42)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 55) : $urandom_range(0, 6);
            add_row(8'(STR_BASE + len));
            cut = len;
            if (len > 0 && $urandom_range(0, 9) == 0)
                cut = $urandom_range(0, len - 1);
            for (int i = 0; i < cut; i++)
                add_row(8'($urandom_range(0, 255)));
        end
        else if (pick < 57)
            add_row(8'(LIST_BASE + $urandom_range(0, 55)));
        else if (pick < 75)
        begin
            // Long string: the length fits one byte, higher bytes are leading zeros.
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 2);
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(56, 80) : $urandom_range(0, 12);
            add_row(8'(STR_SHORT_MAX + n));
            for (int i = n - 1; i > 0; i--)
                add_row(8'h00);
            add_row(8'(len));
            for (int i = 0; i < len; i++)
                add_row(8'($urandom_range(0, 255)));
        end
        else if (pick < 93)
        begin
            // Long list: its length is never consumed, so any length bytes will do.
            n = $urandom_range(1, 8);
            add_row(8'(LIST_SHORT_MAX + n));
            for (int i = 0; i < n; i++)
                add_row(8'($urandom_range(0, 255)));
        end
        else
        begin
            // Noise byte, kept out of the long string range so the stream cannot
            // lock into an endless payload.
            if ($urandom_range(0, 1) == 0)
                add_row(8'($urandom_range(0, 183)));
            else
                add_row(8'($urandom_range(192, 255)));
        end
    endfunction

    // Result side: stalls of random length, with stretches of none.
    initial
    begin
        m_axis_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat (gap_len()) @(negedge clk);
                m_axis_tready = 1'b1;
            end
        end
    end

    // Checks each result against the oldest label due, and labels each
    // accepted request.
    always @(posedge clk)
    begin
        byte_label_t want;
        byte_label_t got;
        byte_label_t lbl;
        byte_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.role = role_e_t'(m_axis_tuser[1:0]);
            got.kind = m_axis_tuser[2];
            got.done = m_axis_tuser[3];
            got.length = m_axis_tdata[63:0];
            got.data = m_axis_tdata[71:64];
            got.last = m_axis_tlast;
            if (labels_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: data %02h role %0d", got.data, got.role);
            end
            else
            begin
                want = labels_due.pop_front();
                if (got.role !== want.role || got.kind !== want.kind
                    || got.length !== want.length || got.done !== want.done
                    || got.last !== want.last || got.data !== want.data
                    || m_axis_tuser[7:4] !== 4'h0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch on byte %02h (expected / actual):", want.data);
                        $display("  data %02h / %02h, role %0d / %0d, kind %0d / %0d",
                                 want.data, got.data, want.role, got.role,
                                 want.kind, got.kind);
                        $display("  length %016h / %016h, done %0d / %0d, last %0d / %0d",
                                 want.length, got.length, want.done, got.done,
                                 want.last, got.last);
                        $display("  tuser spare bits %h", m_axis_tuser[7:4]);
                    end
                end
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            lbl = label_byte(s_axis_tdata);
            if (fixed_use)
                lbl = fixed_lbl;
            labels_due.push_back(lbl);
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int pause_at;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        fixed_lbl = '0;

        // Directed table: extremes of the prefix ranges and the special cases.
        add_fixed(8'h00, ROLE_SINGLE, KIND_STRING, 64'd1, 1'b1, 1'b1);
        add_fixed(8'h7F, ROLE_SINGLE, KIND_STRING, 64'd1, 1'b1, 1'b1);
        add_fixed(8'h80, ROLE_HEADER, KIND_STRING, 64'd0, 1'b1, 1'b0);
        add_fixed(8'hC0, ROLE_HEADER, KIND_LIST, 64'd0, 1'b1, 1'b0);
        add_fixed(8'hF7, ROLE_HEADER, KIND_LIST, 64'd55, 1'b1, 1'b0);
        add_fixed(8'h81, ROLE_HEADER, KIND_STRING, 64'd1, 1'b1, 1'b0);
        add_fixed(8'hAA, ROLE_PAYLOAD, KIND_STRING, 64'd0, 1'b0, 1'b1);
        // Long list with the largest length, then a header is due again.
        add_fixed(8'hFF, ROLE_HEADER, KIND_STRING, 64'd0, 1'b0, 1'b0);
        for (int i = 0; i < 7; i++)
            add_row(8'hFF);
        add_fixed(8'hFF, ROLE_LENGTH, KIND_LIST, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
        // Long string of length zero.
        add_row(8'hB8);
        add_row(8'h00);
        // Long string with a leading zero length byte and a length below 56.
        add_row(8'hB9);
        add_row(8'h00);
        add_row(8'h01);
        add_row(8'h55);
        // Long list of non-canonical length, followed by its children.
        add_row(8'hF8);
        add_row(8'h02);
        add_row(8'h01);
        add_row(8'h02);
        n_directed = rows.size();

        while (rows.size() < n_directed + 550)
            add_random_item();
        pause_at = n_directed + (rows.size() - n_directed) / 2;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < rows.size(); i++)
        begin
            if (i % 100 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            if (i == n_directed || i == pause_at)
            begin
                // Hold off until every result due has come back.
                s_axis_tvalid = 1'b0;
                while (labels_due.size() != 0)
                    @(negedge clk);
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap_len()) @(negedge clk);
            end
            s_axis_tdata = rows[i].b;
            fixed_use = rows[i].fixed;
            fixed_lbl = rows[i].lbl;
            s_axis_tvalid = 1'b1;
            do
                @(negedge clk);
            while (!byte_taken);
        end
        s_axis_tvalid = 1'b0;

        while (labels_due.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (mismatch_count == 0 && labels_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- rlp_header_stream_decoder_core.f -----
rtl/rlph_pkg.sv
rtl/rlph_step.sv
rtl/rlp_header_stream_decoder_core.sv
bench/tb.sv
